// File: rtl/lcgm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the ground marker.
`timescale 1ns / 1ps

package lcgm_pkg;

    // Scan geometry
    localparam int RINGS      = 64;
    localparam int COLUMNS    = 2048;
    localparam int RING_CNT_W = $clog2(RINGS + 1);
    localparam int RING_W     = 6;
    localparam int COL_W      = 11;

    // Field widths
    localparam int COORD_W = 24;
    localparam int THR_W   = 16;
    localparam logic signed [THR_W-1:0] THR_RESET = 16'sd29491;

    // Arithmetic widths
    localparam int MUL_W     = COORD_W + 1;      // difference of two coordinates
    localparam int PROD_W    = 2 * MUL_W;        // one signed product
    localparam int ACC_W     = PROD_W + 2;       // sum of three products
    localparam int TT_W      = 2 * THR_W - 1;    // threshold squared
    localparam int AB_W      = 2 * ACC_W;
    localparam int WIDE_W    = AB_W + 32;
    localparam int SER_STEPS = ACC_W;
    localparam int SER_CNT_W = $clog2(SER_STEPS);
    localparam int COS_SHIFT = 30;
    localparam int DOT_OPS   = 10;
    localparam int R2_OPS    = 3;
    localparam logic [ACC_W-1:0] ONE_METRE_SQ = ACC_W'(65536);

    // Column phases
    localparam logic [1:0] PH_SEEK  = 2'd0;
    localparam logic [1:0] PH_NEXT  = 2'd1;
    localparam logic [1:0] PH_FIRST = 2'd2;
    localparam logic [1:0] PH_LATER = 2'd3;

    // Multiplier operations
    localparam logic [3:0] MUL_PXX = 4'd0;
    localparam logic [3:0] MUL_PYY = 4'd1;
    localparam logic [3:0] MUL_PZZ = 4'd2;
    localparam logic [3:0] MUL_V1X = 4'd3;
    localparam logic [3:0] MUL_V1Y = 4'd4;
    localparam logic [3:0] MUL_V1Z = 4'd5;
    localparam logic [3:0] MUL_V2X = 4'd6;
    localparam logic [3:0] MUL_V2Y = 4'd7;
    localparam logic [3:0] MUL_V2Z = 4'd8;
    localparam logic [3:0] MUL_DX  = 4'd9;
    localparam logic [3:0] MUL_DY  = 4'd10;
    localparam logic [3:0] MUL_DZ  = 4'd11;
    localparam logic [3:0] MUL_TT  = 4'd12;

    // Serial multiplier jobs
    localparam logic [1:0] SER_DSQ = 2'd0;   // D * D
    localparam logic [1:0] SER_AB  = 2'd1;   // A * B
    localparam logic [1:0] SER_ABT = 2'd2;   // (A * B) * T^2

    typedef struct packed {
        logic       load_in;
        logic       head;
        logic       prev_load;
        logic       kill;
        logic       base_load;
        logic       pass_upd;
        logic       acc_clr;
        logic       diff;
        logic       mul_vld;
        logic [3:0] mul_op;
        logic       ser_load;
        logic       ser_step;
        logic       ser_store;
        logic [1:0] ser_src;
        logic       out_load;
        logic       out_prev_ring;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic       over;
        logic [1:0] phase;
        logic       prev_valid;
        logic       p_valid;
        logic       r2_gt;
        logic       fast_fail;
        logic       fast_pass;
        logic       big_pass;
    } stat_t;

endpackage

// File: rtl/lcgm_ctrl.sv
// Controller state machine sequencing one point through the ground marker datapath.
`timescale 1ns / 1ps

module lcgm_ctrl
    import lcgm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t st,
    output cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HEAD   = 4'd1;
    localparam logic [3:0] ST_DISP   = 4'd2;
    localparam logic [3:0] ST_R2     = 4'd3;
    localparam logic [3:0] ST_R2END  = 4'd4;
    localparam logic [3:0] ST_DIFF   = 4'd5;
    localparam logic [3:0] ST_DOT    = 4'd6;
    localparam logic [3:0] ST_CHECK  = 4'd7;
    localparam logic [3:0] ST_SLOAD  = 4'd8;
    localparam logic [3:0] ST_SRUN   = 4'd9;
    localparam logic [3:0] ST_SSTORE = 4'd10;
    localparam logic [3:0] ST_CMP    = 4'd11;
    localparam logic [3:0] ST_PASS   = 4'd12;
    localparam logic [3:0] ST_EMIT1  = 4'd13;
    localparam logic [3:0] ST_EMITA  = 4'd14;
    localparam logic [3:0] ST_EMITB  = 4'd15;

    logic [3:0]           state_reg, state_next;
    logic [SER_CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]           sel_reg, sel_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                cmd.head   = 1'b1;
                state_next = ST_DISP;
            end
            ST_DISP:
            begin
                cmd.acc_clr = 1'b1;
                cnt_next    = '0;
                if (st.over)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    case (st.phase)
                        PH_SEEK: state_next = st.p_valid ? ST_R2 : ST_IDLE;
                        PH_NEXT:
                        begin
                            cmd.prev_load = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        default:
                        begin
                            if (!st.prev_valid)
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (!st.p_valid)
                            begin
                                cmd.kill   = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                state_next = ST_DIFF;
                            end
                        end
                    endcase
                end
            end
            ST_R2:
            begin
                if (cnt_reg < SER_CNT_W'(R2_OPS))
                begin
                    cmd.mul_vld = 1'b1;
                    cmd.mul_op  = MUL_PXX + cnt_reg[3:0];
                    cnt_next    = cnt_reg + SER_CNT_W'(1);
                end
                else
                begin
                    state_next = ST_R2END;
                end
            end
            ST_R2END:
            begin
                if (st.r2_gt)
                begin
                    cmd.base_load = 1'b1;
                    state_next    = ST_EMIT1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DOT;
            end
            ST_DOT:
            begin
                if (cnt_reg < SER_CNT_W'(DOT_OPS))
                begin
                    cmd.mul_vld = 1'b1;
                    cmd.mul_op  = MUL_V1X + cnt_reg[3:0];
                    cnt_next    = cnt_reg + SER_CNT_W'(1);
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (st.fast_fail)
                begin
                    cmd.kill   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (st.fast_pass)
                begin
                    state_next = ST_PASS;
                end
                else
                begin
                    sel_next   = SER_DSQ;
                    state_next = ST_SLOAD;
                end
            end
            ST_SLOAD:
            begin
                cmd.ser_load = 1'b1;
                cmd.ser_src  = sel_reg;
                cnt_next     = '0;
                state_next   = ST_SRUN;
            end
            ST_SRUN:
            begin
                cmd.ser_step = 1'b1;
                cnt_next     = cnt_reg + SER_CNT_W'(1);
                if (cnt_reg == SER_CNT_W'(SER_STEPS - 1))
                begin
                    state_next = ST_SSTORE;
                end
            end
            ST_SSTORE:
            begin
                cmd.ser_store = 1'b1;
                cmd.ser_src   = sel_reg;
                if (sel_reg == SER_ABT)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    sel_next   = (sel_reg == SER_DSQ) ? SER_AB : SER_ABT;
                    state_next = ST_SLOAD;
                end
            end
            ST_CMP:
            begin
                if (st.big_pass)
                begin
                    state_next = ST_PASS;
                end
                else
                begin
                    cmd.kill   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PASS:
            begin
                cmd.pass_upd = 1'b1;
                state_next   = (st.phase == PH_FIRST) ? ST_EMITA : ST_EMIT1;
            end
            ST_EMIT1:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMITA:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_EMITB;
                end
            end
            ST_EMITB:
            begin
                if (out_free)
                begin
                    cmd.out_load      = 1'b1;
                    cmd.out_prev_ring = 1'b1;
                    cmd.out_last      = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= SER_DSQ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/lcgm_datapath.sv
// Datapath: point registers, column state, shared multiplier and bit-serial wide multiplier.
`timescale 1ns / 1ps

module lcgm_datapath
    import lcgm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               st,
    input  logic [3*COORD_W-1:0] in_coords,
    input  logic                in_point_valid,
    input  logic                in_column_start,
    input  logic                cfg_we,
    input  logic [THR_W-1:0]    cfg_wdata,
    output logic [RING_W-1:0]   out_ring,
    output logic [COL_W-1:0]    out_col
);

    // Control state
    logic [RING_CNT_W-1:0]   ring_count_reg;
    logic [COL_W-1:0]        column_count_reg;
    logic [1:0]              phase_reg;
    logic                    prev_valid_reg;
    logic                    over_reg;
    logic signed [THR_W-1:0] thr_reg;

    // Payload
    logic signed [COORD_W-1:0] p_reg [3];
    logic signed [COORD_W-1:0] base_reg [3];
    logic signed [COORD_W-1:0] prev_reg [3];
    logic signed [MUL_W-1:0]   v1_reg [3];
    logic signed [MUL_W-1:0]   v2_reg [3];
    logic                      p_valid_reg;
    logic                      p_start_reg;
    logic [RING_CNT_W-1:0]     cur_ring_reg;

    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_vld_reg;
    logic [3:0]                prod_op_reg;
    logic signed [ACC_W-1:0]   a_reg, b_reg, d_reg;
    logic [TT_W-1:0]           tt_reg;

    logic [WIDE_W-1:0]         mcand_reg, ser_acc_reg, lhs_reg, rhs_reg;
    logic [ACC_W-1:0]          mplier_reg;
    logic [AB_W-1:0]           ab_reg;

    logic [RING_CNT_W-1:0]     ring_cur;
    logic [COL_W+1:0]          col_inc;
    logic signed [MUL_W-1:0]   op_a, op_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [ACC_W-1:0]          dmag;
    logic                      a_zero, b_zero, t_neg, d_pos, d_neg;

    assign ring_cur = p_start_reg ? '0 : ring_count_reg;
    assign col_inc  = {2'b00, column_count_reg} + (COL_W+2)'(1);

    // Column and chain bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg   <= '0;
            column_count_reg <= '1;
            phase_reg        <= PH_SEEK;
            prev_valid_reg   <= 1'b0;
            over_reg         <= 1'b0;
            thr_reg          <= THR_RESET;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            if (cmd.head)
            begin
                if (p_start_reg)
                begin
                    column_count_reg <= (col_inc >= (COL_W+2)'(COLUMNS)) ? '0 : col_inc[COL_W-1:0];
                    phase_reg        <= PH_SEEK;
                    prev_valid_reg   <= 1'b0;
                end
                over_reg <= (ring_cur >= RING_CNT_W'(RINGS));
                if (ring_cur < RING_CNT_W'(RINGS))
                    ring_count_reg <= ring_cur + RING_CNT_W'(1);
            end
            if (cmd.prev_load)
            begin
                prev_valid_reg <= p_valid_reg;
                phase_reg      <= PH_FIRST;
            end
            if (cmd.base_load)
                phase_reg <= PH_NEXT;
            if (cmd.kill)
                prev_valid_reg <= 1'b0;
            if (cmd.pass_upd && phase_reg == PH_FIRST)
                phase_reg <= PH_LATER;
        end
    end

    // Shared signed multiplier operand selection
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.mul_op)
            MUL_PXX: begin op_a = MUL_W'(p_reg[0]); op_b = MUL_W'(p_reg[0]); end
            MUL_PYY: begin op_a = MUL_W'(p_reg[1]); op_b = MUL_W'(p_reg[1]); end
            MUL_PZZ: begin op_a = MUL_W'(p_reg[2]); op_b = MUL_W'(p_reg[2]); end
            MUL_V1X: begin op_a = v1_reg[0]; op_b = v1_reg[0]; end
            MUL_V1Y: begin op_a = v1_reg[1]; op_b = v1_reg[1]; end
            MUL_V1Z: begin op_a = v1_reg[2]; op_b = v1_reg[2]; end
            MUL_V2X: begin op_a = v2_reg[0]; op_b = v2_reg[0]; end
            MUL_V2Y: begin op_a = v2_reg[1]; op_b = v2_reg[1]; end
            MUL_V2Z: begin op_a = v2_reg[2]; op_b = v2_reg[2]; end
            MUL_DX:  begin op_a = v1_reg[0]; op_b = v2_reg[0]; end
            MUL_DY:  begin op_a = v1_reg[1]; op_b = v2_reg[1]; end
            MUL_DZ:  begin op_a = v1_reg[2]; op_b = v2_reg[2]; end
            MUL_TT:  begin op_a = MUL_W'(thr_reg); op_b = MUL_W'(thr_reg); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod     = op_a * op_b;
    assign prod_ext = ACC_W'(prod_reg);
    assign dmag     = d_reg[ACC_W-1] ? ACC_W'(-d_reg) : ACC_W'(d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else
            prod_vld_reg <= cmd.mul_vld;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            for (int i = 0; i < 3; i++)
                p_reg[i] <= in_coords[i*COORD_W +: COORD_W];
            p_valid_reg <= in_point_valid;
            p_start_reg <= in_column_start;
        end
        if (cmd.head)
            cur_ring_reg <= ring_cur;
        if (cmd.base_load)
            base_reg <= p_reg;
        if (cmd.prev_load || cmd.pass_upd)
            prev_reg <= p_reg;
        if (cmd.diff)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i] <= MUL_W'(base_reg[i]) - MUL_W'(prev_reg[i]);
                v2_reg[i] <= MUL_W'(prev_reg[i]) - MUL_W'(p_reg[i]);
            end
        end

        prod_reg    <= prod;
        prod_op_reg <= cmd.mul_op;

        // Fold the previous product into its sum
        if (cmd.acc_clr)
        begin
            a_reg <= '0;
            b_reg <= '0;
            d_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            case (prod_op_reg) inside
                MUL_PXX, MUL_PYY, MUL_PZZ, MUL_V1X, MUL_V1Y, MUL_V1Z:
                    a_reg <= a_reg + prod_ext;
                MUL_V2X, MUL_V2Y, MUL_V2Z:
                    b_reg <= b_reg + prod_ext;
                MUL_DX, MUL_DY, MUL_DZ:
                    d_reg <= d_reg + prod_ext;
                MUL_TT:
                    tt_reg <= prod_reg[TT_W-1:0];
                default: ;
            endcase
        end

        // Bit-serial wide multiplier, one multiplier bit a step
        if (cmd.ser_load)
        begin
            ser_acc_reg <= '0;
            case (cmd.ser_src)
                SER_DSQ:
                begin
                    mcand_reg  <= WIDE_W'(dmag);
                    mplier_reg <= dmag;
                end
                SER_AB:
                begin
                    mcand_reg  <= WIDE_W'(unsigned'(a_reg));
                    mplier_reg <= unsigned'(b_reg);
                end
                default:
                begin
                    mcand_reg  <= WIDE_W'(ab_reg);
                    mplier_reg <= ACC_W'(tt_reg);
                end
            endcase
        end
        else if (cmd.ser_step)
        begin
            if (mplier_reg[0])
                ser_acc_reg <= ser_acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
        if (cmd.ser_store)
        begin
            case (cmd.ser_src)
                SER_DSQ: lhs_reg <= ser_acc_reg << COS_SHIFT;
                SER_AB:  ab_reg  <= ser_acc_reg[AB_W-1:0];
                default: rhs_reg <= ser_acc_reg;
            endcase
        end

        if (cmd.out_load)
        begin
            out_ring <= cmd.out_prev_ring ? RING_W'(cur_ring_reg - RING_CNT_W'(1))
                                          : RING_W'(cur_ring_reg);
            out_col  <= column_count_reg;
        end
    end

    assign a_zero = (a_reg == '0);
    assign b_zero = (b_reg == '0);
    assign t_neg  = thr_reg[THR_W-1];
    assign d_neg  = d_reg[ACC_W-1];
    assign d_pos  = !d_neg && (d_reg != '0);

    always_comb
    begin
        st.over       = over_reg;
        st.phase      = phase_reg;
        st.prev_valid = prev_valid_reg;
        st.p_valid    = p_valid_reg;
        st.r2_gt      = unsigned'(a_reg) > ONE_METRE_SQ;
        st.fast_fail  = a_zero || b_zero || (!t_neg && !d_pos);
        st.fast_pass  = !a_zero && !b_zero && t_neg && !d_neg;
        st.big_pass   = t_neg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);
    end

endmodule

// File: rtl/lidar_column_ground_marker.sv
// Top level of the lidar column ground marker: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Points of an organized scan come in one column at a time, ring 0 first, with the
// column-start flag on ring 0. The block reports the ring and column of every point it
// judges to be ground: the column's base point (first valid point beyond 1 m), then each
// point whose step from the previous ring keeps the base-to-previous direction within
// the cosine threshold; on the first such pass the previous ring is reported too, so one
// point gives at most two result beats, the last one flagged by tlast. The first failed
// test or invalid point ends the column. One point is worked on at a time: s_tready is
// high only between points. A slope test ends early when a zero-length vector or the
// signs of the dot product and threshold settle it; otherwise the bit-serial 52-bit
// multiplier forms the exact squared-cosine comparison in three passes (load, one step
// per multiplier bit, store). Result beats wait in a one-deep output register and are
// held there under back-pressure. The threshold register (signed Q1.15, reset 0.9) is
// written through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce.

module lidar_column_ground_marker
    import lcgm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input points
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // x_coord[23:0], y_coord[47:24], z_coord[71:48]
    input  logic [1:0]  s_tuser,   // point_valid[0], column_start[1]
    // Ground results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // ring_index[5:0], column_index[16:6], zero pad
    output logic        m_tlast,   // last_of_run
    // Cosine threshold register
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    cmd_t              cmd;
    stat_t             st;
    logic [RING_W-1:0] out_ring;
    logic [COL_W-1:0]  out_col;
    logic              last_reg;

    lcgm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lcgm_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .in_coords       (s_tdata),
        .in_point_valid  (s_tuser[0]),
        .in_column_start (s_tuser[1]),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .out_ring        (out_ring),
        .out_col         (out_col)
    );

    // Hold the tlast flag beside the output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            last_reg <= cmd.out_last;
    end

    assign m_tdata = {(24 - RING_W - COL_W)'(0), out_col, out_ring};
    assign m_tlast = last_reg;

endmodule

// File: rtl/lcgm_checker.sv
// Port-level checker for the ground marker, bound to the top level.
`timescale 1ns / 1ps

module lcgm_checker
    import lcgm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // A held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // One point at a time: after a point is taken the input closes
    a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second point taken while busy");

    // A non-final beat is followed straight away by its final partner
    a_pair_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("partner beat of a pair missing");

    // Padding bits above the column stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:RING_W+COL_W] == '0)
        else $error("output padding not zero");

endmodule

bind lidar_column_ground_marker lcgm_checker u_lcgm_checker (.*);
